// ===== sv/ddd_pkg.sv =====
// ----------------------------------------------------------------------------
// ddd_pkg: shared types and constants for the date difference block
// Holds the field widths, the queue depth, the constant reciprocal used for
// division by 25, and the item types passed between front, queue and back.
// ----------------------------------------------------------------------------
package ddd_pkg;

    // Field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;

    // Shifted year (year + 400, less one for January and February)
    localparam int YY_W    = 15;
    // Century count of a year or of a shifted year
    localparam int CENT_W  = 8;
    // Day offset of a month within a March-based year
    localparam int MOFF_W  = 9;
    // Serial day number
    localparam int DN_W    = 23;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Division by 25 as multiply by ceil(2^17 / 25) and shift by 17.
    // Exact for dividends below 43690, which covers every 13-bit value.
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_SHIFT = 17;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One date after the first front stage
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [CENT_W-1:0]  year_cent;  // floor(year / 100)
        logic [YY_W-1:0]    yy;
        logic [CENT_W-1:0]  yy_cent;    // floor(yy / 100)
    } t_date_raw;

    // One date ready for the day number
    typedef struct packed {
        logic [YY_W-1:0]    yy;
        logic [CENT_W-1:0]  yy_cent;
        logic [MOFF_W-1:0]  moff;
        logic [DAY_W-1:0]   day;
    } t_date_nrm;

    // One classified item as held in the queue
    typedef struct packed {
        t_date_nrm start_date;
        t_date_nrm end_date;
        logic      bad;
    } t_item;

endpackage

// ===== sv/ddd_front.sv =====
// ----------------------------------------------------------------------------
// ddd_front: input acceptance and date classification
// Two pipeline stages. The first shifts the years and divides them by 100;
// the second checks both dates for validity and looks up the month offsets.
// ----------------------------------------------------------------------------
module ddd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ddd_pkg::DAY_W-1:0]    i_start_day,
    input  logic [ddd_pkg::MONTH_W-1:0]  i_start_month,
    input  logic [ddd_pkg::YEAR_W-1:0]   i_start_year,
    input  logic [ddd_pkg::DAY_W-1:0]    i_end_day,
    input  logic [ddd_pkg::MONTH_W-1:0]  i_end_month,
    input  logic [ddd_pkg::YEAR_W-1:0]   i_end_year,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ddd_pkg::t_item               o_item
);
    import ddd_pkg::*;

    // Divide a 13-bit value by 25 with a constant reciprocal.
    function automatic logic [CENT_W-1:0] div25(input logic [12:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'(DIV25_MUL);
        return p[DIV25_SHIFT +: CENT_W];
    endfunction

    // First-stage work on one date.
    function automatic t_date_raw prep(input logic [DAY_W-1:0] d,
                                       input logic [MONTH_W-1:0] m,
                                       input logic [YEAR_W-1:0] y);
        t_date_raw r;
        r.day       = d;
        r.month     = m;
        r.year      = y;
        r.year_cent = div25({1'b0, y[YEAR_W-1:2]});
        r.yy        = YY_W'(y) + YY_W'(400) - ((m <= MONTH_W'(2)) ? YY_W'(1) : YY_W'(0));
        r.yy_cent   = div25(r.yy[YY_W-1:2]);
        return r;
    endfunction

    // Days before the first of a month, counting from the first of March.
    function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] o;
        unique case (m)
            4'd3:    o = 9'd0;
            4'd4:    o = 9'd31;
            4'd5:    o = 9'd61;
            4'd6:    o = 9'd92;
            4'd7:    o = 9'd122;
            4'd8:    o = 9'd153;
            4'd9:    o = 9'd184;
            4'd10:   o = 9'd214;
            4'd11:   o = 9'd245;
            4'd12:   o = 9'd275;
            4'd1:    o = 9'd306;
            4'd2:    o = 9'd337;
            default: o = 9'd0;
        endcase
        return o;
    endfunction

    // Length of a month; zero for a month code outside the calendar.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] l;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
            4'd2:    l = leap ? 5'd29 : 5'd28;
            default: l = 5'd0;
        endcase
        return l;
    endfunction

    // Gregorian leap rule from the year and its century count.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                     input logic [CENT_W-1:0] c);
        logic [11:0] c25;
        c25 = 12'({4'b0, c} * 12'd25);
        return (y[1:0] == 2'b00) && ((y[YEAR_W-1:2] != c25) || (c[1:0] == 2'b00));
    endfunction

    function automatic logic date_ok(input t_date_raw r);
        logic [DAY_W-1:0] len;
        len = month_len(r.month, is_leap(r.year, r.year_cent));
        return (r.day != '0) && (r.day <= len);
    endfunction

    function automatic t_date_nrm norm(input t_date_raw r);
        t_date_nrm n;
        n.yy      = r.yy;
        n.yy_cent = r.yy_cent;
        n.moff    = month_offset(r.month);
        n.day     = r.day;
        return n;
    endfunction

    logic      r_v1;
    logic      r_v2;
    t_date_raw r_s1;
    t_date_raw r_e1;
    t_item     r_item;
    logic      en1;
    logic      en2;

    // Stage enables: a stage moves when it is empty or its successor moves.
    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_item  = r_item;

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage one: shifted years and century counts
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_s1 <= prep(i_start_day, i_start_month, i_start_year);
            r_e1 <= prep(i_end_day, i_end_month, i_end_year);
        end
    end

    // Stage two: validity and month offsets
    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_item.start_date <= norm(r_s1);
            r_item.end_date   <= norm(r_e1);
            r_item.bad        <= !(date_ok(r_s1) && date_ok(r_e1));
        end
    end

endmodule

// ===== sv/ddd_queue.sv =====
// ----------------------------------------------------------------------------
// ddd_queue: short queue between the front and the back
// A small circular buffer of classified items, so that either side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module ddd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ddd_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output ddd_pkg::t_item o_item
);
    import ddd_pkg::*;

    t_item          r_buf [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_count;
    logic           push;
    logic           pop;

    assign o_ready = (r_count != QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_buf[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= bump(r_wptr);
            end
            if (pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (push && !pop) begin
                r_count <= r_count + QCW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

endmodule

// ===== sv/ddd_back.sv =====
// ----------------------------------------------------------------------------
// ddd_back: day numbers, difference and result register
// Stage one forms the serial day number of each date; stage two takes the
// difference, adds the end day if asked, saturates and holds the result.
// ----------------------------------------------------------------------------
module ddd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_include_end_day,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ddd_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ddd_pkg::COUNT_W-1:0]   o_day_count,
    output logic                          o_bad_input
);
    import ddd_pkg::*;

    // Serial day number: 365*yy + yy/4 - yy/100 + yy/400 + month offset + day - 1
    function automatic logic [DN_W-1:0] day_number(input t_date_nrm n);
        return DN_W'(n.yy) * DN_W'(365) + DN_W'(n.yy[YY_W-1:2]) - DN_W'(n.yy_cent)
             + DN_W'(n.yy_cent[CENT_W-1:2]) + DN_W'(n.moff) + DN_W'(n.day) - DN_W'(1);
    endfunction

    logic               r_v1;
    logic [DN_W-1:0]    r_dn_start;
    logic [DN_W-1:0]    r_dn_end;
    logic               r_bad1;
    logic               r_ovalid;
    logic [COUNT_W-1:0] r_count;
    logic               r_bad;
    logic               en1;
    logic               en_out;
    logic [DN_W-1:0]    diff;
    logic [DN_W:0]      total;
    logic [COUNT_W-1:0] n_count;

    assign en_out      = !r_ovalid || i_ready;
    assign en1         = !r_v1 || en_out;
    assign o_ready     = en1;
    assign o_valid     = r_ovalid;
    assign o_day_count = r_count;
    assign o_bad_input = r_bad;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en_out) begin
                r_ovalid <= r_v1;
            end
        end
    end

    // Stage one: day numbers of both dates
    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_dn_start <= day_number(i_item.start_date);
            r_dn_end   <= day_number(i_item.end_date);
            r_bad1     <= i_item.bad;
        end
    end

    // Difference (zero unless the end is later), end-day adjustment, saturation, zero for a bad item
    always_comb begin
        diff  = (r_dn_start < r_dn_end) ? (r_dn_end - r_dn_start) : '0;
        total = (DN_W + 1)'(diff) + (DN_W + 1)'(i_include_end_day);
        if (r_bad1) begin
            n_count = '0;
        end else if (total > (DN_W + 1)'(COUNT_MAX)) begin
            n_count = COUNT_MAX;
        end else begin
            n_count = total[COUNT_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (en_out && r_v1) begin
            r_count <= n_count;
            r_bad   <= r_bad1;
        end
    end

endmodule

// ===== sv/date_difference_in_days.sv =====
// ----------------------------------------------------------------------------
// date_difference_in_days: days between two Gregorian dates
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_ready    start and end day, month, year
//   output    o_out_valid / i_out_ready  day count, bad-input flag
//   config    i_cfg_wr_en                include-end-day bit
//
// One beat is accepted per cycle while o_in_ready is high; each result passes
// through five register stages (two front, one queue, two back), the first of
// them loaded at the edge that accepts its input beat.
// The four-entry queue lets the front keep taking beats while the output is
// stalled, until the back, the queue and the front stages hold eight items.
// Reset is synchronous and clears all valid bits and the config bit; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module date_difference_in_days (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ddd_pkg::DAY_W-1:0]     i_start_day,
    input  logic [ddd_pkg::MONTH_W-1:0]   i_start_month,
    input  logic [ddd_pkg::YEAR_W-1:0]    i_start_year,
    input  logic [ddd_pkg::DAY_W-1:0]     i_end_day,
    input  logic [ddd_pkg::MONTH_W-1:0]   i_end_month,
    input  logic [ddd_pkg::YEAR_W-1:0]    i_end_year,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ddd_pkg::COUNT_W-1:0]   o_day_count,
    output logic                          o_bad_input
);
    import ddd_pkg::*;

    logic  r_include_end_day;
    logic  fq_valid;
    logic  fq_ready;
    t_item fq_item;
    logic  qb_valid;
    logic  qb_ready;
    t_item qb_item;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_include_end_day <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_include_end_day <= i_cfg_wr_data;
        end
    end

    // Front: accept and classify
    ddd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_start_day   (i_start_day),
        .i_start_month (i_start_month),
        .i_start_year  (i_start_year),
        .i_end_day     (i_end_day),
        .i_end_month   (i_end_month),
        .i_end_year    (i_end_year),
        .o_valid       (fq_valid),
        .i_ready       (fq_ready),
        .o_item        (fq_item)
    );

    // Queue between the two halves
    ddd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_item  (qb_item)
    );

    // Back: day numbers and result
    ddd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_include_end_day (r_include_end_day),
        .i_valid           (qb_valid),
        .o_ready           (qb_ready),
        .i_item            (qb_item),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_day_count       (o_day_count),
        .o_bad_input       (o_bad_input)
    );

`ifndef SYNTHESIS
    // A bad date always reports a zero count.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_input |-> o_day_count == '0)
        else $error("bad input with nonzero day count");

    // The front only refuses a beat when it holds an item the queue cannot take.
    a_front_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> fq_valid && !fq_ready)
        else $error("front stalled without a full queue");

    // An item the back does not take stays at the head of the queue.
    a_queue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qb_valid && !qb_ready |=> qb_valid && $stable(qb_item))
        else $error("queue head lost while back stalled");
`endif

endmodule
